### src/incscan_pkg.sv
// ---------------------------------------------------------------------------
// incscan_pkg
// Shared types and codes of the include-directive scanner: result records,
// the per-byte record bundle and the record and warning codes.
// ---------------------------------------------------------------------------
package incscan_pkg;

    localparam int LINE_BITS = 24;
    localparam int MAX_RECS  = 4;
    localparam int CNT_W     = $clog2(MAX_RECS + 1);
    localparam int QDEPTH    = 4;
    localparam int QPTR_W    = $clog2(QDEPTH);
    localparam int QCNT_W    = $clog2(QDEPTH + 1);
    localparam int TDATA_W   = 40;

    // record kinds
    localparam logic [1:0] KIND_NAME = 2'd0;
    localparam logic [1:0] KIND_END  = 2'd1;
    localparam logic [1:0] KIND_WARN = 2'd2;
    localparam logic [1:0] KIND_DONE = 2'd3;

    // warning codes
    localparam logic [1:0] WARN_AT_EOL       = 2'd0;
    localparam logic [1:0] WARN_UNTERMINATED = 2'd1;
    localparam logic [1:0] WARN_MULTILINE    = 2'd2;
    localparam logic [1:0] WARN_NO_STRING    = 2'd3;

    typedef struct packed {
        logic [1:0]           kind;
        logic [7:0]           name_char;
        logic [1:0]           code;
        logic [LINE_BITS-1:0] line;
        logic                 incl;
    } rec_t;

    // all records caused by one source byte
    typedef struct packed {
        rec_t [MAX_RECS-1:0] recs;
        logic [CNT_W-1:0]    cnt;
    } bundle_t;

    typedef struct packed {
        logic              full;
        logic              empty;
        logic [QCNT_W-1:0] count;
    } q_stat_t;

    typedef struct packed {
        logic halted;
    } f_stat_t;

endpackage

### src/incscan_front.sv
// ---------------------------------------------------------------------------
// incscan_front
// Byte classifier: tracks scan state, matches the directive keywords and
// builds the bundle of records that one source byte causes.
// ---------------------------------------------------------------------------
module incscan_front import incscan_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       cfg_wr_en,
    input  logic       cfg_wr_data,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,
    input  logic       s_tlast,
    output logic       q_push,
    output bundle_t    q_data,
    input  logic       q_full,
    output f_stat_t    f_stat
);

    typedef enum logic [1:0] {
        M_BETWEEN,
        M_TOKEN,
        M_COMMENT,
        M_STRING
    } mode_t;

    typedef struct packed {
        mode_t                mode;
        logic                 armed;
        logic                 is_inc;
        logic [2:0]           prog;
        logic [3:0]           alive;
        logic                 prev_bs;
        logic                 cr_pend;
        logic                 multi;
        logic [LINE_BITS-1:0] line;
    } scan_t;

    typedef struct packed {
        scan_t               s;
        logic                halted;
        rec_t [MAX_RECS-1:0] recs;
        logic [CNT_W-1:0]    cnt;
    } step_t;

    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_SP    = 8'h20;
    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_SEMI  = 8'h3B;
    localparam logic [7:0] CH_BSL   = 8'h5C;

    localparam logic [55:0] KW_TEXT [4] = '{"include", "INCLUDE",
                                            {"incbin", 8'h00}, {"INCBIN", 8'h00}};
    localparam logic [3:0]  KW_LEN  [4] = '{4'd7, 4'd7, 4'd6, 4'd6};

    localparam scan_t SCAN_RESET = '{mode: M_BETWEEN, armed: 1'b0, is_inc: 1'b0,
                                     prog: 3'd0, alive: 4'd0, prev_bs: 1'b0,
                                     cr_pend: 1'b0, multi: 1'b0,
                                     line: LINE_BITS'(1)};

    function automatic scan_t f_line_inc(scan_t st);
        scan_t r;
        r = st;
        if (r.line != '1) begin
            r.line = r.line + LINE_BITS'(1);
        end
        return r;
    endfunction

    function automatic scan_t f_feed(scan_t st, logic [7:0] c);
        scan_t      r;
        logic [2:0] p;
        logic [2:0] ps;
        logic [7:0] kc;
        r  = st;
        p  = st.prog;
        ps = (p == 3'd7) ? 3'd0 : p;
        for (int k = 0; k < 4; k++) begin
            kc = KW_TEXT[k][8*(6-int'(ps)) +: 8];
            if (r.alive[k] && !(({1'b0, p} < KW_LEN[k]) && (kc == c))) begin
                r.alive[k] = 1'b0;
            end
        end
        r.prog = (p < 3'd7) ? p + 3'd1 : 3'd7;
        for (int k = 0; k < 4; k++) begin
            if (r.alive[k] && (({1'b0, p} + 4'd1) == KW_LEN[k])) begin
                r.armed  = 1'b1;
                r.is_inc = (k < 2);
                r.alive  = 4'd0;
            end
        end
        return r;
    endfunction

    function automatic step_t f_emit(step_t st, logic [1:0] kind, logic [7:0] ch,
                                     logic [1:0] code, logic incl, logic hw);
        step_t r;
        r = st;
        if (!r.halted && (r.cnt < CNT_W'(MAX_RECS))) begin
            r.recs[r.cnt[$clog2(MAX_RECS)-1:0]] = '{kind: kind, name_char: ch,
                                                    code: code, line: r.s.line,
                                                    incl: incl};
            r.cnt = r.cnt + CNT_W'(1);
            if ((kind == KIND_WARN) && hw) begin
                r.halted = 1'b1;
            end
        end
        return r;
    endfunction

    function automatic step_t f_between(step_t st, logic [7:0] c, logic hw);
        step_t r;
        r = st;
        r.s.mode = M_BETWEEN;
        if (c == CH_LF) begin
            if (r.s.armed) begin
                r = f_emit(r, KIND_WARN, 8'd0, WARN_AT_EOL, 1'b0, hw);
            end
            r.s.armed = 1'b0;
            r.s = f_line_inc(r.s);
        end else if ((c == CH_SP) || (c == CH_TAB) || (c == CH_CR)) begin
            r.s.mode = M_BETWEEN;
        end else if (c == CH_SEMI) begin
            r.s.mode = M_COMMENT;
        end else if (c == CH_QUOTE) begin
            r.s.mode    = M_STRING;
            r.s.prev_bs = 1'b0;
            r.s.cr_pend = 1'b0;
            r.s.multi   = 1'b0;
        end else begin
            if (r.s.armed) begin
                r = f_emit(r, KIND_WARN, 8'd0, WARN_NO_STRING, 1'b0, hw);
            end
            r.s.armed = 1'b0;
            r.s.mode  = M_TOKEN;
            r.s.prog  = 3'd0;
            r.s.alive = 4'hF;
            r.s = f_feed(r.s, c);
        end
        return r;
    endfunction

    function automatic step_t f_finish(step_t st, logic term, logic hw);
        step_t r;
        r = st;
        if (!term) begin
            r = f_emit(r, KIND_WARN, 8'd0, WARN_UNTERMINATED, 1'b0, hw);
        end
        if (r.s.armed) begin
            r.s.armed = 1'b0;
            if (r.s.multi) begin
                r = f_emit(r, KIND_WARN, 8'd0, WARN_MULTILINE, 1'b0, hw);
            end else begin
                r = f_emit(r, KIND_END, 8'd0, 2'd0, r.s.is_inc, hw);
            end
        end
        r.s.mode    = M_BETWEEN;
        r.s.prev_bs = 1'b0;
        r.s.cr_pend = 1'b0;
        return r;
    endfunction

    function automatic step_t f_scan(step_t st, logic [7:0] c, logic hw);
        step_t r;
        logic  skip;
        r    = st;
        skip = 1'b0;
        case (r.s.mode)
            M_STRING: begin
                if (r.s.cr_pend) begin
                    r.s.cr_pend = 1'b0;
                    if (c == CH_LF) begin
                        r.s  = f_line_inc(r.s);
                        skip = 1'b1;
                    end
                end
                if (!skip) begin
                    if (c == CH_QUOTE) begin
                        r = f_finish(r, 1'b1, hw);
                    end else if ((c == CH_CR) || (c == CH_LF)) begin
                        if (r.s.prev_bs) begin
                            r.s.multi   = 1'b1;
                            r.s.prev_bs = 1'b0;
                            if (c == CH_LF) begin
                                r.s = f_line_inc(r.s);
                            end else begin
                                r.s.cr_pend = 1'b1;
                            end
                        end else begin
                            r = f_finish(r, 1'b0, hw);
                            r = f_between(r, c, hw);
                        end
                    end else begin
                        if (r.s.armed && !r.s.multi) begin
                            r = f_emit(r, KIND_NAME, c, 2'd0, 1'b0, hw);
                        end
                        r.s.prev_bs = (c == CH_BSL);
                    end
                end
            end
            M_COMMENT: begin
                if (c == CH_LF) begin
                    r = f_between(r, c, hw);
                end
            end
            M_TOKEN: begin
                if ((c == CH_SP) || (c == CH_TAB) || (c == CH_CR) || (c == CH_LF) ||
                    (c == CH_QUOTE) || (c == CH_SEMI)) begin
                    r = f_between(r, c, hw);
                end else begin
                    r.s = f_feed(r.s, c);
                end
            end
            default: begin
                r = f_between(r, c, hw);
            end
        endcase
        return r;
    endfunction

    scan_t scan_reg;
    logic  halted_reg;
    logic  hw_reg;
    step_t step_start;
    step_t step_a;
    step_t step_b;
    step_t step_next;
    logic  accept;

    assign s_tready = !q_full;
    assign accept   = s_tvalid && s_tready;

    always_comb begin
        step_start.s      = scan_reg;
        step_start.halted = halted_reg;
        step_start.recs   = '0;
        step_start.cnt    = '0;
        step_a = f_scan(step_start, s_tdata, hw_reg);
        step_b = step_a;
        if (s_tlast) begin
            // virtual line feed, close an open string, then the done record
            step_b = f_scan(step_a, CH_LF, hw_reg);
            if (step_b.s.mode == M_STRING) begin
                step_b = f_finish(step_b, 1'b0, hw_reg);
            end
            step_b   = f_emit(step_b, KIND_DONE, 8'd0, 2'd0, 1'b0, hw_reg);
            step_b.s = SCAN_RESET;
        end
        // once halted the byte is swallowed with no effect
        step_next = halted_reg ? step_start : step_b;
    end

    assign q_push      = accept && (step_next.cnt != '0);
    assign q_data.recs = step_next.recs;
    assign q_data.cnt  = step_next.cnt;
    assign f_stat.halted = halted_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            scan_reg   <= SCAN_RESET;
            halted_reg <= 1'b0;
            hw_reg     <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                hw_reg <= cfg_wr_data;
            end
            if (accept) begin
                scan_reg   <= step_next.s;
                halted_reg <= step_next.halted;
            end
        end
    end

endmodule

### src/incscan_queue.sv
// ---------------------------------------------------------------------------
// incscan_queue
// Short first-in first-out queue of record bundles between the classifier
// and the record serializer.
// ---------------------------------------------------------------------------
module incscan_queue import incscan_pkg::*; (
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    push,
    input  bundle_t push_data,
    input  logic    pop,
    output bundle_t pop_data,
    output q_stat_t q_stat
);

    bundle_t           mem_reg [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg;
    logic [QCNT_W-1:0] count_next;

    assign pop_data     = mem_reg[rd_ptr_reg];
    assign q_stat.full  = (count_reg == QCNT_W'(QDEPTH));
    assign q_stat.empty = (count_reg == '0);
    assign q_stat.count = count_reg;

    always_comb begin
        count_next = count_reg;
        if (push && !pop) begin
            count_next = count_reg + QCNT_W'(1);
        end else if (pop && !push) begin
            count_next = count_reg - QCNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + QPTR_W'(1);
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + QPTR_W'(1);
            end
            count_reg <= count_next;
        end
    end

endmodule

### src/incscan_back.sv
// ---------------------------------------------------------------------------
// incscan_back
// Record serializer: holds one bundle and sends its records one transfer
// per cycle while m_tready is high, marking the last record of each bundle.
// ---------------------------------------------------------------------------
module incscan_back import incscan_pkg::*; (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               q_empty,
    input  bundle_t            q_data,
    output logic               q_pop,
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [TDATA_W-1:0] m_tdata,
    output logic [1:0]         m_tuser,
    output logic               m_tlast
);

    localparam int IDX_W = $clog2(MAX_RECS);

    bundle_t          cur_reg;
    logic             cur_valid_reg;
    logic [IDX_W-1:0] idx_reg;
    rec_t             rec;
    logic             last;
    logic             advance;

    assign rec  = cur_reg.recs[idx_reg];
    assign last = ({1'b0, idx_reg} == (cur_reg.cnt - CNT_W'(1)));

    // take the next bundle when idle or when the final record goes out
    assign advance = !cur_valid_reg || (m_tready && last);
    assign q_pop   = advance && !q_empty;

    assign m_tvalid = cur_valid_reg;
    assign m_tuser  = rec.kind;
    assign m_tlast  = last;
    assign m_tdata  = {(TDATA_W - 35)'(0), rec.incl, rec.line, rec.code, rec.name_char};

    always_ff @(posedge aclk) begin
        if (q_pop) begin
            cur_reg <= q_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cur_valid_reg <= 1'b0;
            idx_reg       <= '0;
        end else begin
            if (advance) begin
                cur_valid_reg <= !q_empty;
                idx_reg       <= '0;
            end else if (m_tready) begin
                idx_reg <= idx_reg + IDX_W'(1);
            end
        end
    end

endmodule

### src/asm_include_directive_scanner.sv
// ---------------------------------------------------------------------------
// asm_include_directive_scanner
// Scans assembler source one byte per transfer and reports include/incbin
// filenames, warnings and end-of-text records.
// ---------------------------------------------------------------------------
//  channel | dir | fields
//  --------+-----+-------------------------------------------------------------
//  s_      | in  | tdata[7:0] source_byte, tlast end_of_text
//  m_      | out | tuser[1:0] record_kind, tdata name_char/warning_code/
//          |     | line_number/is_source_include, tlast last_of_run
//  cfg_    | in  | cfg_wr_data halt_on_warning, written when cfg_wr_en is high
//
// the classifier takes one byte per cycle while the queue is not full; all records of
// a byte are built in that same cycle and stored as one bundle in a four-entry queue
// the serializer sends one record per cycle while m_tready is high; the queue
// absorbs short bursts
// s_tready drops only while the queue is full; m_tready stalls only the back
// reset is synchronous and active low, no clearing pass
// ---------------------------------------------------------------------------
module asm_include_directive_scanner import incscan_pkg::*; (
    input  logic               aclk,
    input  logic               aresetn,
    // configuration
    input  logic               cfg_wr_en,
    input  logic               cfg_wr_data,     // halt_on_warning
    // source bytes
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [7:0]         s_tdata,         // [7:0] source_byte
    input  logic               s_tlast,         // end_of_text
    // result records
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [TDATA_W-1:0] m_tdata,         // [7:0] name_char, [9:8] warning_code,
                                                // [33:10] line_number,
                                                // [34] is_source_include, rest zero
    output logic [1:0]         m_tuser,         // [1:0] record_kind
    output logic               m_tlast          // last_of_run
);

    // queue handshake between front and back
    logic    q_push;
    logic    q_pop;
    bundle_t q_in;
    bundle_t q_out;
    q_stat_t q_stat;
    f_stat_t f_stat;

    // front: classify each byte and build its records
    incscan_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tlast     (s_tlast),
        .q_push      (q_push),
        .q_data      (q_in),
        .q_full      (q_stat.full),
        .f_stat      (f_stat)
    );

    // bundle queue
    incscan_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_data (q_in),
        .pop       (q_pop),
        .pop_data  (q_out),
        .q_stat    (q_stat)
    );

    // back: one record transfer per cycle while m_tready is high
    incscan_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_empty  (q_stat.empty),
        .q_data   (q_out),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    // a bundle is never written into a full queue
    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        q_push |-> !q_stat.full)
        else $error("bundle pushed into full queue");

    // the serializer never takes from an empty queue
    a_no_underflow: assert property (@(posedge aclk) disable iff (!aresetn)
        q_pop |-> !q_stat.empty)
        else $error("bundle popped from empty queue");

    // once halted, only reset brings the scanner back
    a_halt_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        f_stat.halted |=> f_stat.halted)
        else $error("halted state cleared without reset");

endmodule
